[hw/rtl/rtf_pkg.sv]
// rtf_pkg: shared types and constants for the region tag filter.
// No dependencies; used by all files of the block but rtf_stream_if.
`timescale 1ns / 1ps

package rtf_pkg;

   // field widths
   localparam int CELL_W     = 16;
   localparam int WORD_W     = 32;
   localparam int LEVEL_W    = 3;
   localparam int ENTRY_W    = 4;
   localparam int COMP_W     = 3;
   localparam int FLOOR_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   // doubled centre: (2*index+1)*spacing + 2*origin, exact
   localparam int ODD_W      = CELL_W + 1;
   localparam int CENTRE_W   = ODD_W + WORD_W;
   // register stages from request to response
   localparam int NUM_STAGES = 6;

   // request kinds
   typedef enum logic [1:0] {
      REQ_QUERY     = 2'd0,
      REQ_BOX_COORD = 2'd1,
      REQ_BOX_ATTR  = 2'd2,
      REQ_SPACING   = 2'd3
   } req_kind_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_COUNT = 2'd3;

   // coordinate selectors
   localparam logic [COMP_W-1:0] COMP_LOWER_X = 3'd0;
   localparam logic [COMP_W-1:0] COMP_LOWER_Y = 3'd1;
   localparam logic [COMP_W-1:0] COMP_LOWER_Z = 3'd2;
   localparam logic [COMP_W-1:0] COMP_UPPER_X = 3'd3;
   localparam logic [COMP_W-1:0] COMP_UPPER_Y = 3'd4;
   localparam logic [COMP_W-1:0] COMP_UPPER_Z = 3'd5;

   typedef struct packed {
      req_kind_type               req_type;
      logic signed [CELL_W-1:0]   cell_x;
      logic signed [CELL_W-1:0]   cell_y;
      logic signed [CELL_W-1:0]   cell_z;
      logic [LEVEL_W-1:0]         level;
      logic [ENTRY_W-1:0]         entry;
      logic [COMP_W-1:0]          component;
      logic signed [WORD_W-1:0]   word_value;
      logic [FLOOR_W-1:0]         box_min_level;
      logic                       box_is_inverse;
   } req_payload_type;

   typedef struct packed {
      logic keep_tag;
      logic in_removal_box;
      logic in_protect_box;
      logic outside_protect_box;
   } rsp_payload_type;

   // request fields carried down the pipe once the cell indexes are consumed
   typedef struct packed {
      req_kind_type               kind;
      logic [LEVEL_W-1:0]         level;
      logic                       level_ok;
      logic [ENTRY_W-1:0]         entry;
      logic [COMP_W-1:0]          component;
      logic signed [WORD_W-1:0]   word_value;
      logic [FLOOR_W-1:0]         box_min_level;
      logic                       box_is_inverse;
   } item_type;

   // stage loads and table write strobes from the pipe control
   typedef struct packed {
      logic [NUM_STAGES:1] load;
      logic                leave1;
      logic                leave4;
   } pipe_ctrl_type;

endpackage

[hw/rtl/rtf_stream_if.sv]
// rtf_stream_if: valid/ready channel with a typed payload.
// Payload types come from rtf_pkg at instantiation.
`timescale 1ns / 1ps

interface rtf_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/rtf_pipe_ctrl.sv]
// rtf_pipe_ctrl: valid bits and per-stage ready chain of the filter pipe.
// Depends on rtf_pkg.
`timescale 1ns / 1ps

module rtf_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   input  logic                   st5_query,
   output rtf_pkg::pipe_ctrl_type ctrl,
   output logic                   req_ready,
   output logic                   rsp_valid
);

   logic [rtf_pkg::NUM_STAGES:1] valid_ff;
   logic [rtf_pkg::NUM_STAGES:1] valid_in;
   logic [rtf_pkg::NUM_STAGES:1] rdy;

   // a stage takes new data when empty or when its content moves on
   always_comb begin
      rdy[rtf_pkg::NUM_STAGES] = !valid_ff[rtf_pkg::NUM_STAGES] || rsp_ready;
      for (int k = rtf_pkg::NUM_STAGES - 1; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      valid_in[1] = req_valid;
      for (int k = 2; k < rtf_pkg::NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      // only queries produce a response
      valid_in[rtf_pkg::NUM_STAGES] = valid_ff[rtf_pkg::NUM_STAGES-1] && st5_query;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= rtf_pkg::NUM_STAGES; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign ctrl.load   = rdy;
   assign ctrl.leave1 = valid_ff[1] && rdy[2];
   assign ctrl.leave4 = valid_ff[4] && rdy[5];
   assign req_ready   = rdy[1];
   assign rsp_valid   = valid_ff[rtf_pkg::NUM_STAGES];

endmodule

[hw/rtl/rtf_centre.sv]
// rtf_centre: stages 1-4, spacing table, odd index, product and doubled cell centre.
// Depends on rtf_pkg.
`timescale 1ns / 1ps

module rtf_centre #(
   parameter int MAX_LEVELS = 8,
   parameter int SPACE_DIM  = 3
) (
   input  logic                                  clock,
   input  rtf_pkg::pipe_ctrl_type                ctrl,
   input  rtf_pkg::req_payload_type              req_item,
   input  logic signed [rtf_pkg::WORD_W-1:0]     origin [SPACE_DIM],
   output rtf_pkg::item_type                     item4,
   output logic signed [rtf_pkg::CENTRE_W-1:0]   centre4 [SPACE_DIM]
);

   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int EXT_W = rtf_pkg::CENTRE_W - rtf_pkg::WORD_W - 1;

   rtf_pkg::req_payload_type              st1_ff;
   rtf_pkg::item_type                     item2_in, item2_ff, item3_ff, item4_ff;
   logic signed [rtf_pkg::CELL_W-1:0]     cell1 [SPACE_DIM];
   logic signed [rtf_pkg::ODD_W-1:0]      odd2_in [SPACE_DIM];
   logic signed [rtf_pkg::ODD_W-1:0]      odd2_ff [SPACE_DIM];
   logic signed [rtf_pkg::WORD_W-1:0]     spacing_ff [MAX_LEVELS];
   logic signed [rtf_pkg::WORD_W-1:0]     spacing2_in, spacing2_ff;
   logic signed [rtf_pkg::CENTRE_W-1:0]   prod3_in [SPACE_DIM];
   logic signed [rtf_pkg::CENTRE_W-1:0]   prod3_ff [SPACE_DIM];
   logic signed [rtf_pkg::CENTRE_W-1:0]   origin2 [SPACE_DIM];
   logic signed [rtf_pkg::CENTRE_W-1:0]   centre4_in [SPACE_DIM];
   logic signed [rtf_pkg::CENTRE_W-1:0]   centre4_ff [SPACE_DIM];

   // stage 1: request register
   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         st1_ff <= req_item;
      end
   end

   // spacing table, written as the request leaves stage 1 (where queries read it)
   always_ff @(posedge clock) begin
      if (ctrl.leave1 && st1_ff.req_type == rtf_pkg::REQ_SPACING &&
          32'(st1_ff.entry) < MAX_LEVELS) begin
         spacing_ff[LVL_W'(st1_ff.entry)] <= st1_ff.word_value;
      end
   end

   // stage 2 inputs: odd index 2*i+1, spacing lookup
   always_comb begin
      for (int a = 0; a < SPACE_DIM; a++) begin
         case (a)
            0:       cell1[a] = st1_ff.cell_x;
            1:       cell1[a] = st1_ff.cell_y;
            default: cell1[a] = st1_ff.cell_z;
         endcase
         odd2_in[a] = {cell1[a], 1'b1};
      end
      item2_in.kind           = st1_ff.req_type;
      item2_in.level          = st1_ff.level;
      item2_in.level_ok       = 32'(st1_ff.level) < MAX_LEVELS;
      item2_in.entry          = st1_ff.entry;
      item2_in.component      = st1_ff.component;
      item2_in.word_value     = st1_ff.word_value;
      item2_in.box_min_level  = st1_ff.box_min_level;
      item2_in.box_is_inverse = st1_ff.box_is_inverse;
      spacing2_in = item2_in.level_ok ? spacing_ff[LVL_W'(st1_ff.level)] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         item2_ff    <= item2_in;
         odd2_ff     <= odd2_in;
         spacing2_ff <= spacing2_in;
      end
   end

   // stage 3: exact product, 17 x 32 signed
   always_comb begin
      for (int a = 0; a < SPACE_DIM; a++) begin
         prod3_in[a] = odd2_ff[a] * spacing2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         item3_ff <= item2_ff;
         prod3_ff <= prod3_in;
      end
   end

   // stage 4: add the doubled origin
   always_comb begin
      for (int a = 0; a < SPACE_DIM; a++) begin
         origin2[a]    = {{EXT_W{origin[a][rtf_pkg::WORD_W-1]}}, origin[a], 1'b0};
         centre4_in[a] = prod3_ff[a] + origin2[a];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         item4_ff   <= item3_ff;
         centre4_ff <= centre4_in;
      end
   end

   assign item4   = item4_ff;
   assign centre4 = centre4_ff;

endmodule

[hw/rtl/rtf_box_lanes.sv]
// rtf_box_lanes: box table, one compare lane per box (stage 5) and flag merge (stage 6).
// Depends on rtf_pkg.
`timescale 1ns / 1ps

module rtf_box_lanes #(
   parameter int MAX_BOXES = 16,
   parameter int SPACE_DIM = 3
) (
   input  logic                                clock,
   input  rtf_pkg::pipe_ctrl_type              ctrl,
   input  rtf_pkg::item_type                   item4,
   input  logic signed [rtf_pkg::CENTRE_W-1:0] centre4 [SPACE_DIM],
   input  logic [rtf_pkg::COUNT_W-1:0]         box_count,
   output logic                                st5_query,
   output rtf_pkg::rsp_payload_type            rsp_item
);

   localparam int BOX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int AX_W  = $clog2(SPACE_DIM);
   localparam int EXT_W = rtf_pkg::CENTRE_W - rtf_pkg::WORD_W - 1;

   logic signed [rtf_pkg::WORD_W-1:0] lower_ff [MAX_BOXES][SPACE_DIM];
   logic signed [rtf_pkg::WORD_W-1:0] upper_ff [MAX_BOXES][SPACE_DIM];
   logic [rtf_pkg::FLOOR_W-1:0]       floor_ff [MAX_BOXES];
   logic [MAX_BOXES-1:0]              inverse_ff;

   logic [1:0]                        axis;
   logic                              to_upper;
   logic                              comp_ok;
   logic                              coord_ok;

   logic [MAX_BOXES-1:0]              act5_in, ins5_in;
   logic [MAX_BOXES-1:0]              act5_ff, ins5_ff, inv5_ff;
   logic                              query5_ff;
   rtf_pkg::rsp_payload_type          rsp_in, rsp_ff;
   logic                              in_plain, in_prot, out_prot;

   // coordinate selector decode
   always_comb begin
      axis     = 2'd0;
      to_upper = 1'b0;
      comp_ok  = 1'b1;
      case (item4.component)
         rtf_pkg::COMP_LOWER_X: axis = 2'd0;
         rtf_pkg::COMP_LOWER_Y: axis = 2'd1;
         rtf_pkg::COMP_LOWER_Z: axis = 2'd2;
         rtf_pkg::COMP_UPPER_X: begin axis = 2'd0; to_upper = 1'b1; end
         rtf_pkg::COMP_UPPER_Y: begin axis = 2'd1; to_upper = 1'b1; end
         rtf_pkg::COMP_UPPER_Z: begin axis = 2'd2; to_upper = 1'b1; end
         default:               comp_ok = 1'b0;
      endcase
      coord_ok = comp_ok && (int'(axis) < SPACE_DIM);
   end

   // box table writes, as the request leaves stage 4 (where queries read it)
   always_ff @(posedge clock) begin
      if (ctrl.leave4 && 32'(item4.entry) < MAX_BOXES) begin
         case (item4.kind)
            rtf_pkg::REQ_BOX_COORD: begin
               if (coord_ok) begin
                  if (to_upper) begin
                     upper_ff[BOX_W'(item4.entry)][AX_W'(axis)] <= item4.word_value;
                  end else begin
                     lower_ff[BOX_W'(item4.entry)][AX_W'(axis)] <= item4.word_value;
                  end
               end
            end
            rtf_pkg::REQ_BOX_ATTR: begin
               floor_ff[BOX_W'(item4.entry)]   <= item4.box_min_level;
               inverse_ff[BOX_W'(item4.entry)] <= item4.box_is_inverse;
            end
            default: ;
         endcase
      end
   end

   // one lane per box: active check and strict containment on every axis
   for (genvar b = 0; b < MAX_BOXES; b++) begin : g_lane
      always_comb begin
         logic signed [rtf_pkg::CENTRE_W-1:0] lo2;
         logic signed [rtf_pkg::CENTRE_W-1:0] hi2;
         logic                                hit;
         hit = 1'b1;
         for (int a = 0; a < SPACE_DIM; a++) begin
            lo2 = {{EXT_W{lower_ff[b][a][rtf_pkg::WORD_W-1]}}, lower_ff[b][a], 1'b0};
            hi2 = {{EXT_W{upper_ff[b][a][rtf_pkg::WORD_W-1]}}, upper_ff[b][a], 1'b0};
            if (!(centre4[a] > lo2 && centre4[a] < hi2)) begin
               hit = 1'b0;
            end
         end
         ins5_in[b] = hit;
         act5_in[b] = (item4.kind == rtf_pkg::REQ_QUERY) && item4.level_ok &&
                      (int'(box_count) > b) && ({1'b0, item4.level} >= floor_ff[b]);
      end
   end

   // stage 5: lane results
   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         act5_ff   <= act5_in;
         ins5_ff   <= ins5_in;
         inv5_ff   <= inverse_ff;
         query5_ff <= (item4.kind == rtf_pkg::REQ_QUERY);
      end
   end

   // stage 6: merge lanes into the response flags
   always_comb begin
      in_plain = |(act5_ff & ~inv5_ff & ins5_ff);
      in_prot  = |(act5_ff & inv5_ff & ins5_ff);
      out_prot = |(act5_ff & inv5_ff & ~ins5_ff);
      rsp_in.keep_tag            = in_prot || !(in_plain || out_prot);
      rsp_in.in_removal_box      = in_plain;
      rsp_in.in_protect_box      = in_prot;
      rsp_in.outside_protect_box = out_prot;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[rtf_pkg::NUM_STAGES]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign st5_query = query5_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hw/rtl/region_tag_filter.sv]
// region_tag_filter: six register stages from request acceptance to response valid.
// Throughput one request per cycle unless the response stalls; the slowest step is
// the 17 x 32 signed multiply of stage 3, then one 49-bit compare pair per box lane.
// Reset clears the valid bits, the origin registers and the box count; the box and
// spacing tables are not reset and must be written before a query reads them.
// Depends on rtf_pkg, rtf_stream_if, rtf_pipe_ctrl, rtf_centre and rtf_box_lanes.
`timescale 1ns / 1ps

module region_tag_filter #(
   parameter int MAX_BOXES  = 16,
   parameter int MAX_LEVELS = 8,
   parameter int SPACE_DIM  = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rtf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtf_pkg::WORD_W-1:0]      csr_data,
   rtf_stream_if.sink                      req,
   rtf_stream_if.source                    rsp
);

   localparam int AX_W = $clog2(SPACE_DIM);

   rtf_pkg::pipe_ctrl_type                ctrl;
   logic signed [rtf_pkg::WORD_W-1:0]     origin_ff [SPACE_DIM];
   logic [rtf_pkg::COUNT_W-1:0]           box_count_ff;
   rtf_pkg::item_type                     item4;
   logic signed [rtf_pkg::CENTRE_W-1:0]   centre4 [SPACE_DIM];
   logic                                  st5_query;
   rtf_pkg::rsp_payload_type              rsp_item;
   logic                                  req_ready;
   logic                                  rsp_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < SPACE_DIM; a++) begin
            origin_ff[a] <= '0;
         end
         box_count_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_index inside {rtf_pkg::CSR_ORIGIN_X, rtf_pkg::CSR_ORIGIN_Y,
                               rtf_pkg::CSR_ORIGIN_Z}) begin
            if (int'(csr_index) < SPACE_DIM) begin
               origin_ff[AX_W'(csr_index)] <= csr_data;
            end
         end else if (csr_index == rtf_pkg::CSR_BOX_COUNT) begin
            box_count_ff <= csr_data[rtf_pkg::COUNT_W-1:0];
         end
      end
   end

   rtf_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .rsp_ready (rsp.ready),
      .st5_query (st5_query),
      .ctrl      (ctrl),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   rtf_centre #(
      .MAX_LEVELS (MAX_LEVELS),
      .SPACE_DIM  (SPACE_DIM)
   ) u_centre (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_item (req.payload),
      .origin   (origin_ff),
      .item4    (item4),
      .centre4  (centre4)
   );

   rtf_box_lanes #(
      .MAX_BOXES (MAX_BOXES),
      .SPACE_DIM (SPACE_DIM)
   ) u_lanes (
      .clock     (clock),
      .ctrl      (ctrl),
      .item4     (item4),
      .centre4   (centre4),
      .box_count (box_count_ff),
      .st5_query (st5_query),
      .rsp_item  (rsp_item)
   );

   assign req.ready   = req_ready;
   assign rsp.valid   = rsp_valid;
   assign rsp.payload = rsp_item;

   // no response straight out of reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid right after reset");

   // a held response must freeze the last stage
   a_hold_blocks_load : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !ctrl.load[rtf_pkg::NUM_STAGES])
      else $error("output stage reloaded while response stalled");

   // keep decision agrees with the flags
   a_keep_rule : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.keep_tag == (rsp.payload.in_protect_box ||
         !(rsp.payload.in_removal_box || rsp.payload.outside_protect_box))))
      else $error("keep_tag inconsistent with box flags");

   // a response only follows a query in stage 5
   a_query_only : assert property (@(posedge clock) disable iff (reset)
      (ctrl.load[rtf_pkg::NUM_STAGES] && !st5_query) |=> !rsp.valid)
      else $error("response raised for a table write");

endmodule
